@@ hdl/rdts_pkg.sv @@
// Package for the repeating deadline timer set: widths, opcodes, result kinds.
// Used by the interface files and the top level.
package rdts_pkg;
  localparam int SLOTS = 64;
  localparam int MAX_FIRES = 63;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int FIRE_W = $clog2(MAX_FIRES + 1);
  localparam int MEM_W = 48 + 31 + 31 + 31;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_DEL = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [1:0] K_ADD = 2'd0;
  localparam logic [1:0] K_FIRE = 2'd1;
  localparam logic [1:0] K_POLL = 2'd2;
  localparam logic [1:0] K_DEL = 2'd3;

  localparam logic [30:0] FOREVER = 31'h7FFFFFFF;
  localparam logic [47:0] MASK48 = 48'hFFFFFFFFFFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [30:0] delay_ms;
    logic signed [31:0] repeat_count;
    logic [30:0] timer_id;
    logic [47:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] result_id;
    logic        ok;
    logic [30:0] wait_ms;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [47:0] deadline;
    logic [30:0] interval;
    logic [30:0] remaining;
    logic [30:0] ident;
  } slot_t;

  // Deadline = time + interval, saturated at the 48-bit limit.
  function automatic logic [47:0] sat_add(input logic [47:0] t, input logic [30:0] iv);
    logic [48:0] s;
    s = {1'b0, t} + {18'd0, iv};
    return s[48] ? MASK48 : s[47:0];
  endfunction
endpackage

@@ hdl/rdts_in_if.sv @@
// Valid/ready channel interface for input transactions.
// Depends on rdts_pkg.
interface rdts_in_if;
  import rdts_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/rdts_out_if.sv @@
// Valid/ready channel interface for result transactions.
// Depends on rdts_pkg.
interface rdts_out_if;
  import rdts_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/rdts_ram.sv @@
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module rdts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/repeating_deadline_timer_set.sv @@
// Repeating deadline timer set: slot fields in one RAM, valid bits in flops.
// Add: result straight from the scan state, with no RAM scan. Delete: result after a full RAM scan.
// Poll: a full RAM scan, then after each fire a full rescan of the RAM, up to MAX_FIRES fires.
// One item at a time; input is ready again the cycle after the last result is taken.
// Reset is synchronous: clears valid bits and time, sets next id to 1.
// Depends on rdts_pkg, rdts_in_if, rdts_out_if, rdts_ram.
module repeating_deadline_timer_set (
  input logic clk,
  input logic rst,
  rdts_in_if.sink  in_ch,
  rdts_out_if.source out_ch
);
  import rdts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_UPD = 3'd4;

  logic [2:0] state;
  in_t req;
  logic [SLOTS-1:0] valid;
  logic [47:0] time_now;
  logic [30:0] next_ident;

  // Scan control: addr issued, a registered copy for returned data.
  logic [SLOT_W:0] cnt;
  logic rd_live;
  logic [SLOT_W-1:0] rd_idx;
  logic found;
  logic [SLOT_W-1:0] best_idx;
  slot_t best;
  logic [FIRE_W-1:0] fires;
  logic out_valid;
  out_t out_data;

  logic we;
  logic [SLOT_W-1:0] waddr;
  slot_t wdata, rdata;
  logic [MEM_W-1:0] rraw;

  rdts_ram #(.WIDTH(MEM_W), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(cnt[SLOT_W-1:0]), .rdata(rraw)
  );
  assign rdata = slot_t'(rraw);

  // Lowest free slot, found combinationally over the valid flops.
  logic free_any;
  logic [SLOT_W-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Candidate compare for the earliest-deadline scan.
  logic better;
  always_comb begin
    better = !found || rdata.deadline < best.deadline ||
             (rdata.deadline == best.deadline && rdata.ident < best.ident);
  end

  // Remaining after a fire.
  logic [30:0] rem_dec;
  assign rem_dec = (best.remaining == FOREVER) ? FOREVER : best.remaining - 31'd1;

  logic [47:0] time_left;
  assign time_left = best.deadline - time_now;

  logic [30:0] add_rem;
  always_comb begin
    if (req.repeat_count == -32'sd1) add_rem = FOREVER;
    else if (req.repeat_count <= 32'sd0) add_rem = 31'd1;
    else add_rem = req.repeat_count[30:0];
  end

  always_comb begin
    we = 1'b0;
    waddr = best_idx;
    wdata = best;
    if (state == S_SCAN && req.opcode == OP_ADD && free_any) begin
      we = 1'b1;
      waddr = free_idx;
      wdata = '{deadline: sat_add(time_now, req.delay_ms),
                interval: req.delay_ms, remaining: add_rem, ident: next_ident};
    end else if (state == S_UPD) begin
      we = 1'b1;
      wdata.remaining = rem_dec;
      if (best.interval != 31'd0) wdata.deadline = sat_add(time_now, best.interval);
    end
  end

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      time_now <= '0;
      next_ident <= 31'd1;
      out_valid <= 1'b0;
      rd_live <= 1'b0;
      cnt <= '0;
      found <= 1'b0;
      fires <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req <= in_ch.data;
            cnt <= '0;
            found <= 1'b0;
            fires <= '0;
            if (in_ch.data.opcode == OP_POLL) time_now <= in_ch.data.now_ms;
            if (in_ch.data.opcode != OP_NOP) state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (req.opcode == OP_ADD) begin
            // Add needs no RAM scan: write and report at once.
            out_valid <= 1'b1;
            out_data <= '{kind: K_ADD, result_id: free_any ? next_ident : 31'd0,
                          ok: free_any, wait_ms: 31'd0, last: 1'b1};
            if (free_any) begin
              valid[free_idx] <= 1'b1;
              next_ident <= (next_ident == FOREVER) ? 31'd1 : next_ident + 31'd1;
            end
            state <= S_IDLE;
          end else begin
            rd_live <= (cnt < (SLOT_W + 1)'(SLOTS));
            if (cnt < (SLOT_W + 1)'(SLOTS)) begin
              rd_idx <= cnt[SLOT_W-1:0];
              cnt <= cnt + 1'b1;
            end
            if (rd_live && valid[rd_idx]) begin
              if (req.opcode == OP_DEL) begin
                if (!found && rdata.ident == req.timer_id) begin
                  found <= 1'b1;
                  best_idx <= rd_idx;
                end
              end else if (better) begin
                found <= 1'b1;
                best_idx <= rd_idx;
                best <= rdata;
              end
            end
            if (cnt == (SLOT_W + 1)'(SLOTS) && !rd_live) state <= S_DEC;
          end
        end
        S_DEC: begin
          if (!out_valid) begin
            if (req.opcode == OP_DEL) begin
              if (found) valid[best_idx] <= 1'b0;
              out_valid <= 1'b1;
              out_data <= '{kind: K_DEL, result_id: 31'd0, ok: found,
                            wait_ms: 31'd0, last: 1'b1};
              state <= S_IDLE;
            end else if (!found || best.deadline > time_now ||
                         fires == FIRE_W'(MAX_FIRES)) begin
              out_valid <= 1'b1;
              out_data <= '{kind: K_POLL, result_id: 31'd0, ok: 1'b0,
                            wait_ms: (!found || best.deadline <= time_now) ? 31'd0 :
                              (time_left[47:31] != '0 ? FOREVER : time_left[30:0]),
                            last: 1'b1};
              state <= S_IDLE;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data <= '{kind: K_FIRE, result_id: best.ident, ok: 1'b0,
                          wait_ms: 31'd0, last: 1'b0};
            fires <= fires + 1'b1;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (rem_dec == 31'd0) valid[best_idx] <= 1'b0;
          cnt <= '0;
          found <= 1'b0;
          state <= S_SCAN;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // Input is taken only when no result is pending.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |-> !out_valid)
    else $error("input accepted with pending result");
  // A poll never emits more fires than the cap.
  a_fire_cap: assert property (@(posedge clk) disable iff (rst)
    fires <= FIRE_W'(MAX_FIRES))
    else $error("fire count above cap");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
`endif
endmodule
